### sv/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg: shared types and constants of the byte decompressor
// Command format between the token parser and the copy engine, the engine
// state codes and the header magic.
// ----------------------------------------------------------------------------
package lzd_pkg;

   localparam int WINDOW_SIZE      = 4096;
   localparam int WINDOW_BITS      = $clog2(WINDOW_SIZE);
   localparam int BYTES_PER_RESULT = 8;
   localparam int HEADER_LEN       = 16;
   localparam int CMD_QUEUE_DEPTH  = 4;
   localparam int RUN_BITS         = 9;
   localparam logic [7:0] LONG_RUN_BASE = 8'h12;

   // Kind of work one input item asks of the copy engine.
   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_HDR,
      CMD_LIT,
      CMD_COPY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic                   first;
      logic [3:0]             hpos;
      logic [7:0]             data;
      logic [RUN_BITS-1:0]    len;
      logic [WINDOW_BITS-1:0] distance;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_PREP1,
      B_PREP2,
      B_READ,
      B_WRITE,
      B_PUSH
   } back_state_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
   localparam logic [1:0] ST_BAD_SKIP = 2'd2;

   // Expected magic byte at header positions zero to three.
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      unique case (idx)
         2'd0: m = 8'h59;
         2'd1: m = 8'h61;
         2'd2: m = 8'h7A;
         default: m = 8'h30;
      endcase
      return m;
   endfunction

endpackage

### sv/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front: header and token parser
// Tracks header position, flag bits and multi-byte back-reference tokens and
// turns each input item into one command for the copy engine.
// ----------------------------------------------------------------------------
module lzd_front
   import lzd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] in_byte,
   input  logic       in_first,
   output cmd_type    cmd
);

   logic [4:0]             hpos_ff, hpos_in, hpos_base;
   logic [7:0]             flags_ff, flags_in, flags_base;
   logic [3:0]             fleft_ff, fleft_in, fleft_base;
   logic [1:0]             phase_ff, phase_in, phase_base;
   logic [3:0]             nib_ff, nib_in, nib_base;
   logic [WINDOW_BITS-1:0] pdist_ff, pdist_in, pdist_base;

   // A first item restarts parsing from clean state.
   always_comb begin
      hpos_base  = in_first ? 5'd0 : hpos_ff;
      flags_base = in_first ? 8'd0 : flags_ff;
      fleft_base = in_first ? 4'd0 : fleft_ff;
      phase_base = in_first ? 2'd0 : phase_ff;
      nib_base   = in_first ? 4'd0 : nib_ff;
      pdist_base = in_first ? '0 : pdist_ff;
   end

   // Classify the byte and advance the token state.
   always_comb begin
      hpos_in  = hpos_base;
      flags_in = flags_base;
      fleft_in = fleft_base;
      phase_in = phase_base;
      nib_in   = nib_base;
      pdist_in = pdist_base;
      cmd.kind  = CMD_NONE;
      cmd.first = in_first;
      cmd.hpos  = hpos_base[3:0];
      cmd.data  = in_byte;
      cmd.len   = '0;
      cmd.distance = pdist_base | WINDOW_BITS'(in_byte);
      if (hpos_base < 5'(HEADER_LEN)) begin
         cmd.kind = CMD_HDR;
         hpos_in  = hpos_base + 5'd1;
      end else begin
         priority case (phase_base)
            2'd1: begin
               if (nib_base != 4'd0) begin
                  cmd.kind = CMD_COPY;
                  cmd.len  = RUN_BITS'(nib_base) + RUN_BITS'(2);
                  phase_in = 2'd0;
               end else begin
                  phase_in = 2'd2;
               end
               pdist_in = pdist_base | WINDOW_BITS'(in_byte);
            end
            2'd2: begin
               cmd.kind = CMD_COPY;
               cmd.distance = pdist_base;
               cmd.len  = RUN_BITS'(in_byte) + RUN_BITS'(LONG_RUN_BASE);
               phase_in = 2'd0;
            end
            default: begin
               phase_in = 2'd0;
               if (fleft_base == 4'd0) begin
                  flags_in = in_byte;
                  fleft_in = 4'd8;
               end else begin
                  flags_in = {flags_base[6:0], 1'b0};
                  fleft_in = fleft_base - 4'd1;
                  if (flags_base[7]) begin
                     cmd.kind = CMD_LIT;
                  end else begin
                     nib_in   = in_byte[7:4];
                     pdist_in = {in_byte[3:0], 8'h00};
                     phase_in = 2'd1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hpos_ff  <= '0;
         flags_ff <= '0;
         fleft_ff <= '0;
         phase_ff <= '0;
         nib_ff   <= '0;
         pdist_ff <= '0;
      end else if (take) begin
         hpos_ff  <= hpos_in;
         flags_ff <= flags_in;
         fleft_ff <= fleft_in;
         phase_ff <= phase_in;
         nib_ff   <= nib_in;
         pdist_ff <= pdist_in;
      end
   end

endmodule

### sv/lzd_fifo.sv
// ----------------------------------------------------------------------------
// lzd_fifo: command queue
// A short first-in first-out queue that decouples the parser from the engine.
// ----------------------------------------------------------------------------
module lzd_fifo
   import lzd_pkg::*;
#(
   parameter int DEPTH = CMD_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = entry_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

### sv/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back: copy engine
// Runs header checks, writes literals and copied bytes into the history,
// applies skip and emit limits and packs decoded bytes into results.
// ----------------------------------------------------------------------------
module lzd_back
   import lzd_pkg::*;
#(
   parameter int BPR = BYTES_PER_RESULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] skip_count,
   input  logic [31:0] out_limit,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_data,
   output logic [3:0]  rsp_count,
   output logic        rsp_last,
   output logic        rsp_done,
   output logic [1:0]  rsp_status
);

   localparam int WB = WINDOW_BITS;

   back_state_type      state_ff, state_in;
   logic                rst_ff, rst_in;
   logic [WB-1:0]       ptr_ff, ptr_in;
   logic [31:0]         dsize_ff, dsize_in;
   logic [31:0]         prod_ff, prod_in;
   logic [31:0]         skip_ff, skip_in;
   logic [31:0]         emit_ff, emit_in;
   logic [1:0]          err_ff, err_in;
   logic                fin_ff, fin_in;
   logic [63:0]         buf_ff, buf_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic                last_ff, last_in;
   logic [RUN_BITS-1:0] len_ff, len_in;
   logic [WB:0]         dist_ff, dist_in;
   logic                full_ff, full_in;
   logic                dfin_ff, dfin_in;
   logic                rdz_ff;
   logic [7:0]          rdata_ff;
   logic                ov_ff, ov_in;
   logic [63:0]         od_ff, od_in;
   logic [3:0]          oc_ff, oc_in;
   logic                ol_ff, ol_in;
   logic                odn_ff, odn_in;
   logic [1:0]          ost_ff, ost_in;

   logic [7:0]          hist [WINDOW_SIZE];
   logic                mem_we, rd_en;
   logic [WB-1:0]       rd_addr;

   // Effect of producing one decoded byte.
   logic                do_prod, p_skip, p_fin;
   logic [7:0]          pv;
   logic [31:0]         p_prod, p_emit;
   logic [3:0]          p_cnt;
   logic [63:0]         p_buf;
   logic [31:0]         left32;
   logic [RUN_BITS-1:0] em;
   logic [32:0]         emsum;
   logic                out_free;

   always_comb begin
      pv     = (state_ff == B_WRITE) ? (rdz_ff ? 8'h00 : rdata_ff) : cmd.data;
      p_skip = (skip_ff != '0);
      p_prod = prod_ff + 32'd1;
      p_emit = p_skip ? emit_ff : emit_ff + 32'd1;
      p_fin  = (p_prod >= dsize_ff) || (p_emit >= out_limit);
      p_cnt  = p_skip ? cnt_ff : cnt_ff + 4'd1;
      p_buf  = buf_ff;
      if (!p_skip) begin
         p_buf[{cnt_ff[2:0], 3'b000} +: 8] = pv;
      end
   end

   assign out_free = !ov_ff || rsp_ready;
   assign left32   = dsize_ff - prod_ff;
   assign em       = ({23'd0, len_ff} > skip_ff) ? len_ff - skip_ff[RUN_BITS-1:0] : '0;
   assign emsum    = {1'b0, emit_ff} + 33'(em);

   // Engine sequencing.
   always_comb begin
      state_in = state_ff;
      rst_in   = rst_ff;
      ptr_in   = ptr_ff;
      dsize_in = dsize_ff;
      prod_in  = prod_ff;
      skip_in  = skip_ff;
      emit_in  = emit_ff;
      err_in   = err_ff;
      fin_in   = fin_ff;
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      dist_in  = dist_ff;
      full_in  = full_ff;
      dfin_in  = dfin_ff;
      ov_in    = ov_ff && !rsp_ready;
      od_in    = od_ff;
      oc_in    = oc_ff;
      ol_in    = ol_ff;
      odn_in   = odn_ff;
      ost_in   = ost_ff;
      cmd_pop  = 1'b0;
      do_prod  = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff - dist_ff[WB-1:0];
      unique case (state_ff)
         B_IDLE: begin
            if (cmd_valid && cmd.first && !rst_ff) begin
               // Clear the per-file state, then take the command next cycle.
               rst_in   = 1'b1;
               ptr_in   = '0;
               dsize_in = '0;
               prod_in  = '0;
               skip_in  = '0;
               emit_in  = '0;
               err_in   = ST_OK;
               fin_in   = 1'b0;
            end else if (cmd_valid) begin
               cmd_pop  = 1'b1;
               rst_in   = 1'b0;
               last_in  = 1'b1;
               state_in = B_PUSH;
               if (!fin_ff) begin
                  unique case (cmd.kind)
                     CMD_HDR: begin
                        if (cmd.hpos < 4'd4) begin
                           if (cmd.data != magic_byte(cmd.hpos[1:0])) begin
                              err_in = ST_BAD_MAGIC;
                           end
                        end else if (cmd.hpos < 4'd8) begin
                           dsize_in = {dsize_ff[23:0], cmd.data};
                        end
                        if (cmd.hpos == 4'(HEADER_LEN - 1)) begin
                           skip_in = skip_count;
                           priority if (err_ff != ST_OK) begin
                              fin_in = 1'b1;
                           end else if (out_limit == '0) begin
                              fin_in = 1'b1;
                           end else if (skip_count > dsize_ff) begin
                              err_in = ST_BAD_SKIP;
                              fin_in = 1'b1;
                           end else if (dsize_ff == '0) begin
                              fin_in = 1'b1;
                           end
                        end
                     end
                     CMD_LIT: begin
                        do_prod = 1'b1;
                     end
                     CMD_COPY: begin
                        len_in   = cmd.len;
                        dist_in  = {1'b0, cmd.distance} + (WB+1)'(1);
                        state_in = B_PREP1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         B_PREP1: begin
            // Clamp the run to the bytes left in the file.
            if ({23'd0, len_ff} >= left32) begin
               len_in  = left32[RUN_BITS-1:0];
               full_in = 1'b1;
            end else begin
               full_in = 1'b0;
            end
            state_in = B_PREP2;
         end
         B_PREP2: begin
            // Tell ahead whether this run ends the file.
            dfin_in  = full_ff || (emsum >= {1'b0, out_limit});
            state_in = B_READ;
         end
         B_READ: begin
            rd_en    = 1'b1;
            state_in = B_WRITE;
         end
         B_WRITE: begin
            do_prod = 1'b1;
            len_in  = len_ff - RUN_BITS'(1);
            if (p_fin || len_ff == RUN_BITS'(1)) begin
               last_in  = 1'b1;
               state_in = B_PUSH;
            end else if (p_cnt == 4'(BPR)) begin
               last_in  = 1'b0;
               state_in = B_PUSH;
            end else begin
               state_in = B_READ;
            end
         end
         B_PUSH: begin
            if (out_free) begin
               ov_in    = 1'b1;
               od_in    = buf_ff;
               oc_in    = cnt_ff;
               ol_in    = last_ff;
               odn_in   = last_ff ? fin_ff : dfin_ff;
               ost_in   = err_ff;
               buf_in   = '0;
               cnt_in   = '0;
               state_in = last_ff ? B_IDLE : B_READ;
            end
         end
         default: state_in = B_IDLE;
      endcase
      if (do_prod) begin
         ptr_in  = ptr_ff + WB'(1);
         prod_in = p_prod;
         skip_in = p_skip ? skip_ff - 32'd1 : skip_ff;
         emit_in = p_emit;
         fin_in  = p_fin;
         cnt_in  = p_cnt;
         buf_in  = p_buf;
      end
   end

   assign mem_we = do_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rst_ff   <= 1'b0;
         ptr_ff   <= '0;
         dsize_ff <= '0;
         prod_ff  <= '0;
         skip_ff  <= '0;
         emit_ff  <= '0;
         err_ff   <= ST_OK;
         fin_ff   <= 1'b1;
         buf_ff   <= '0;
         cnt_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rst_ff   <= rst_in;
         ptr_ff   <= ptr_in;
         dsize_ff <= dsize_in;
         prod_ff  <= prod_in;
         skip_ff  <= skip_in;
         emit_ff  <= emit_in;
         err_ff   <= err_in;
         fin_ff   <= fin_in;
         buf_ff   <= buf_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      len_ff  <= len_in;
      dist_ff <= dist_in;
      full_ff <= full_in;
      dfin_ff <= dfin_in;
      od_ff   <= od_in;
      oc_ff   <= oc_in;
      ol_ff   <= ol_in;
      odn_ff  <= odn_in;
      ost_ff  <= ost_in;
   end

   // History memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist[ptr_ff] <= pv;
      end
      if (rd_en) begin
         rdata_ff <= hist[rd_addr];
         rdz_ff   <= (dist_ff > {1'b0, prod_ff[WB-1:0]}) && (prod_ff[31:WB] == '0);
      end
   end

   assign rsp_valid  = ov_ff;
   assign rsp_data   = od_ff;
   assign rsp_count  = oc_ff;
   assign rsp_last   = ol_ff;
   assign rsp_done   = odn_ff;
   assign rsp_status = ost_ff;

endmodule

### sv/lz_backref_byte_decompressor.sv
// ----------------------------------------------------------------------------
// lz_backref_byte_decompressor: streaming back-reference byte decoder
// Top level with the configuration registers, parser, queue and copy engine.
// ----------------------------------------------------------------------------
// A compressed file enters one byte per item, req_tuser marking its first
// header byte. Header, flag and token bytes each pass through the copy engine
// as one command, and a first item first clears the file state; a literal
// yields one result. A back-reference copies its run one history byte at a
// time, each byte needing a read of the history memory followed by a write
// into it, and the engine stalls on a pending result while rsp_tready is low.
// A short command queue lets the parser take up to four more items meanwhile.
// Every item yields at least one result; a result with zero bytes carries
// status. The history memory needs no clearing pass after reset.
module lz_backref_byte_decompressor
   import lzd_pkg::*;
#(
   parameter int BPR = BYTES_PER_RESULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tuser,   // in_first
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_data, out_count, out_done, out_status, zero
   output logic        rsp_tlast,   // out_last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] skip_ff, limit_ff;
   logic        take, full, cmd_valid, cmd_pop;
   cmd_type     fcmd, qcmd;
   logic [63:0] r_data;
   logic [3:0]  r_count;
   logic        r_done;
   logic [1:0]  r_status;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? limit_ff : skip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff  <= '0;
         limit_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2]) begin
            limit_ff <= csr_pwdata;
         end else begin
            skip_ff <= csr_pwdata;
         end
      end
   end

   assign req_tready = !full;
   assign take       = req_tvalid && !full;

   lzd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .in_byte  (req_tdata),
      .in_first (req_tuser),
      .cmd      (fcmd)
   );

   lzd_fifo #(.DEPTH(CMD_QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (fcmd),
      .full      (full),
      .pop       (cmd_pop),
      .not_empty (cmd_valid),
      .pop_data  (qcmd)
   );

   lzd_back #(.BPR(BPR)) u_back (
      .clock      (clock),
      .reset      (reset),
      .skip_count (skip_ff),
      .out_limit  (limit_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (qcmd),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (r_data),
      .rsp_count  (r_count),
      .rsp_last   (rsp_tlast),
      .rsp_done   (r_done),
      .rsp_status (r_status)
   );

   assign rsp_tdata = {1'b0, r_status, r_done, r_count, r_data};

   // A result never holds more bytes than a result can carry.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:64] <= 4'(BPR))
      else $error("result byte count too large");

   // A status-only result always closes its item.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[67:64] == 4'd0 |-> rsp_tlast)
      else $error("empty result not marked last");

   // Results before the last one of an item are full.
   a_full_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[67:64] == 4'(BPR))
      else $error("partial result before end of item");

   // No result is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
